// File: design/vtcc_pkg.sv
// Shared types, constants and codes for the voltage-triggered checkpoint controller.
package vtcc_pkg;

  // Size of the live region and of its checkpoint copy.
  localparam int REGION_WORDS = 2048;
  localparam int ADDR_W       = $clog2(REGION_WORDS);

  // Field widths fixed by the interface.
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 11;
  localparam int WORD_W   = 16;
  localparam int CODE_W   = 12;
  localparam int MV_W     = 13;
  localparam int REF_W    = 12;
  localparam int ACTION_W = 3;
  localparam int CFG_IDX_W = 2;

  // Converter scaling: mv = 2*code*ref/4095, done as a reciprocal multiply.
  localparam int              CODE_FULL_SCALE = 4095;
  localparam int              PROD_W          = CODE_W + REF_W;      // code*ref
  localparam int              DIVIDEND_W      = PROD_W + 1;          // 2*code*ref
  localparam int              RECIP_W         = 26;
  localparam logic [25:0]     RECIP_4095      = 26'd33562626;        // (2^37-2)/4095
  localparam int              RECIP_SHIFT     = 37;
  localparam int              QUOT_W          = 14;
  localparam int              QPROD_W         = DIVIDEND_W + RECIP_W;
  localparam int              REM_W           = DIVIDEND_W + 1;

  // Register reset values.
  localparam logic [MV_W-1:0]  OFF_MV_RESET     = 13'd1900;
  localparam logic [MV_W-1:0]  SAVE_MV_RESET    = 13'd2200;
  localparam logic [MV_W-1:0]  RESUME_MV_RESET  = 13'd2500;
  localparam logic [REF_W-1:0] REF_MV_RESET     = 12'd1200;
  localparam logic [MV_W-1:0]  LAST_VOLT_RESET  = 13'd3300;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_MV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_MV   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESUME_MV = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_MV    = 2'd3;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_POLL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Action codes reported with a poll.
  localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SAVED     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SAVED_OFF = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_OFF       = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESTORED  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_DISCARDED = 3'd5;

  // Request word.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] word_index;
    logic [WORD_W-1:0]  write_data;
    logic [CODE_W-1:0]  supply_code;
    logic               code_ready;
    logic [WORD_W-1:0]  stack_pointer;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic [WORD_W-1:0]   read_data;
    logic [MV_W-1:0]     voltage_mv;
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   restored_stack_pointer;
    logic                checkpoint_valid;
    logic                power_off_seen;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                live_write;
    logic                read_capture;
    logic                volt_take;
    logic                set_valid;
    logic                clr_valid;
    logic                set_off;
    logic                clr_off;
    logic                save_sp;
    logic                restore_sp;
    logic                set_action;
    logic [ACTION_W-1:0] action;
    logic                copy_start;
    logic                copy_restore;
    logic                copy_step;
    logic                finish;
  } vtcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              below_off;
    logic              below_save;
    logic              at_resume;
    logic              valid_flag;
    logic              off_flag;
    logic              copy_last;
  } vtcc_status_t;

endpackage

// File: design/vtcc_datapath.sv
// Datapath: configuration, live and checkpoint memories, voltage conversion and flags.
module vtcc_datapath import vtcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_data,
  input  in_item_t             item,
  input  vtcc_cmd_t            cmd,
  output vtcc_status_t         status,
  output out_item_t            result
);

  // Configuration registers.
  logic [MV_W-1:0]  off_mv;
  logic [MV_W-1:0]  save_mv;
  logic [MV_W-1:0]  resume_mv;
  logic [REF_W-1:0] ref_mv;

  // Latched request word.
  in_item_t req;

  // Persistent state.
  logic [WORD_W-1:0] saved_sp;
  logic              valid_flag;
  logic              off_flag;
  logic [MV_W-1:0]   last_volt;

  // Per-word result fields.
  logic [WORD_W-1:0]   rd_out;
  logic [MV_W-1:0]     volt;
  logic [ACTION_W-1:0] act;
  logic [WORD_W-1:0]   rsp;

  // Conversion pipeline.
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] dividend;
  logic [QPROD_W-1:0]    qprod;
  logic [QUOT_W-1:0]     qest;
  logic [REM_W-1:0]      qest_times_fs;
  logic [REM_W-1:0]      remainder;
  logic [QUOT_W-1:0]     quot;
  logic [MV_W-1:0]       volt_calc;

  // Memories and copy engine.
  logic [WORD_W-1:0] live_mem [REGION_WORDS];
  logic [WORD_W-1:0] ckpt_mem [REGION_WORDS];
  logic [WORD_W-1:0] live_rdata;
  logic [WORD_W-1:0] ckpt_rdata;
  logic [ADDR_W-1:0] req_addr;
  logic              req_in_range;
  logic [ADDR_W-1:0] copy_cnt;
  logic [ADDR_W-1:0] copy_wr_addr;
  logic              copy_wr_pend;
  logic              copy_restore;
  logic [ADDR_W-1:0] live_raddr;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      off_mv    <= OFF_MV_RESET;
      save_mv   <= SAVE_MV_RESET;
      resume_mv <= RESUME_MV_RESET;
      ref_mv    <= REF_MV_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OFF_MV:    off_mv    <= cfg_data;
        CFG_SAVE_MV:   save_mv   <= cfg_data;
        CFG_RESUME_MV: resume_mv <= cfg_data;
        CFG_REF_MV:    ref_mv    <= cfg_data[REF_W-1:0];
        default:       ;
      endcase
    end
  end

  // Request address decode.
  assign req_addr     = ADDR_W'(req.word_index);
  assign req_in_range = (32'(req.word_index) < REGION_WORDS);

  // Scale the code: product, reciprocal multiply, then one correction step.
  assign dividend      = {prod, 1'b0};
  assign qprod         = QPROD_W'(dividend) * QPROD_W'(RECIP_4095);
  assign qest_times_fs = {qest, 12'd0} - REM_W'(qest);
  assign remainder     = REM_W'(dividend) - qest_times_fs;
  assign quot          = (remainder >= REM_W'(CODE_FULL_SCALE)) ? qest + 14'd1 : qest;
  assign volt_calc     = quot[MV_W-1:0];

  always_ff @(posedge clk) begin
    prod <= req.supply_code * ref_mv;
    qest <= qprod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  end

  // Request latch and per-word result fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req    <= item;
      rd_out <= '0;
      volt   <= '0;
      act    <= ACT_NONE;
      rsp    <= '0;
    end else begin
      if (cmd.read_capture && req_in_range) begin
        rd_out <= live_rdata;
      end
      if (cmd.volt_take) begin
        volt <= req.code_ready ? volt_calc : last_volt;
      end
      if (cmd.set_action) begin
        act <= cmd.action;
      end
      if (cmd.restore_sp) begin
        rsp <= saved_sp;
      end
    end
  end

  // Persistent flags, last voltage and saved stack pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_sp   <= '0;
      valid_flag <= 1'b0;
      off_flag   <= 1'b0;
      last_volt  <= LAST_VOLT_RESET;
    end else begin
      if (cmd.volt_take && req.code_ready) begin
        last_volt <= volt_calc;
      end
      if (cmd.save_sp) begin
        saved_sp <= req.stack_pointer;
      end
      if (cmd.set_valid) begin
        valid_flag <= 1'b1;
      end else if (cmd.clr_valid) begin
        valid_flag <= 1'b0;
      end
      if (cmd.set_off) begin
        off_flag <= 1'b1;
      end else if (cmd.clr_off) begin
        off_flag <= 1'b0;
      end
    end
  end

  // Copy engine: one word read per step and written to the other memory in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_wr_pend <= 1'b0;
    end else begin
      copy_wr_pend <= cmd.copy_step;
    end
  end

  always_ff @(posedge clk) begin
    copy_wr_addr <= copy_cnt;
    if (cmd.copy_start) begin
      copy_cnt     <= '0;
      copy_restore <= cmd.copy_restore;
    end else if (cmd.copy_step) begin
      copy_cnt <= copy_cnt + 1'b1;
    end
  end

  assign live_raddr = (cmd.copy_step && !copy_restore) ? copy_cnt : req_addr;

  // Live memory: request writes, or checkpoint words during a restore.
  always_ff @(posedge clk) begin
    if (copy_wr_pend && copy_restore) begin
      live_mem[copy_wr_addr] <= ckpt_rdata;
    end else if (cmd.live_write && req_in_range) begin
      live_mem[req_addr] <= req.write_data;
    end
    live_rdata <= live_mem[live_raddr];
  end

  // Checkpoint memory: filled from live words during a save.
  always_ff @(posedge clk) begin
    if (copy_wr_pend && !copy_restore) begin
      ckpt_mem[copy_wr_addr] <= live_rdata;
    end
    ckpt_rdata <= ckpt_mem[copy_cnt];
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.read_data              <= rd_out;
      result.voltage_mv             <= volt;
      result.action                 <= act;
      result.restored_stack_pointer <= rsp;
      result.checkpoint_valid       <= valid_flag;
      result.power_off_seen         <= off_flag;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.mode       = req.mode;
    status.below_off  = (volt < off_mv);
    status.below_save = (volt < save_mv);
    status.at_resume  = (volt >= resume_mv);
    status.valid_flag = valid_flag;
    status.off_flag   = off_flag;
    status.copy_last  = (copy_cnt == ADDR_W'(REGION_WORDS - 1));
  end

endmodule

// File: design/vtcc_ctrl.sv
// Controller: sequences word access, conversion, checkpoint policy and memory copies.
module vtcc_ctrl import vtcc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  output logic         done,
  input  vtcc_status_t status,
  output vtcc_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CONV,
    S_VOLT,
    S_POLICY,
    S_COPY,
    S_COPY_TAIL,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.mode)
          MODE_POLL:  state_next = S_CONV;
          MODE_WRITE: begin
            cmd.live_write = 1'b1;
            state_next     = S_FINISH;
          end
          MODE_READ:  state_next = S_READ;
          default:    state_next = S_FINISH;
        endcase
      end
      S_READ: begin
        cmd.read_capture = 1'b1;
        state_next       = S_FINISH;
      end
      S_CONV: begin
        state_next = S_VOLT;
      end
      S_VOLT: begin
        cmd.volt_take = 1'b1;
        state_next    = S_POLICY;
      end
      S_POLICY: begin
        cmd.set_action = 1'b1;
        cmd.action     = ACT_NONE;
        state_next     = S_FINISH;
        if (status.valid_flag && status.off_flag) begin
          // Supply back after a power-off: restore the checkpoint.
          if (status.at_resume) begin
            cmd.action       = ACT_RESTORED;
            cmd.restore_sp   = 1'b1;
            cmd.clr_valid    = 1'b1;
            cmd.clr_off      = 1'b1;
            cmd.copy_start   = 1'b1;
            cmd.copy_restore = 1'b1;
            state_next       = S_COPY;
          end
        end else if (status.valid_flag) begin
          // Checkpoint held without a power-off: flag off, or discard it.
          if (status.below_off) begin
            cmd.action  = ACT_OFF;
            cmd.set_off = 1'b1;
          end else if (status.at_resume) begin
            cmd.action    = ACT_DISCARDED;
            cmd.clr_valid = 1'b1;
          end
        end else begin
          // No checkpoint yet: save on a droop, flag off on a deep droop.
          if (status.below_off) begin
            cmd.set_off = 1'b1;
            cmd.action  = ACT_OFF;
          end
          if (status.below_save) begin
            cmd.save_sp      = 1'b1;
            cmd.set_valid    = 1'b1;
            cmd.copy_start   = 1'b1;
            cmd.copy_restore = 1'b0;
            cmd.action       = status.below_off ? ACT_SAVED_OFF : ACT_SAVED;
            state_next       = S_COPY;
          end
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (status.copy_last) begin
          state_next = S_COPY_TAIL;
        end
      end
      S_COPY_TAIL: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: design/voltage_triggered_checkpoint_controller.sv
// Top level of the voltage-triggered checkpoint controller.
//
//   Channel   Signals                          Handshake
//   request   start, item (in_item_t)          taken when start is high and busy is low
//   result    done, result (out_item_t)        valid for the one cycle that done is high
//   config    cfg_write, cfg_index, cfg_data   written when cfg_write is high
//
// A write word passes through DISPATCH and FINISH before done, a read adds READ,
// a poll CONV, VOLT and POLICY. A save or restore adds COPY and COPY_TAIL for the
// word-by-word copy between live and checkpoint memories, one word per cycle per port.
// A new request is accepted in the cycle that done is shown.
// Reset clears the flags, restores register defaults and sets the last voltage
// to 3300 mV; memory contents are undefined until written. The receiver cannot stall.
module voltage_triggered_checkpoint_controller import vtcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  output logic                 done,
  output out_item_t            result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_data
);

  vtcc_cmd_t    cmd;
  vtcc_status_t status;

  // Sequencing.
  vtcc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  // Storage and arithmetic.
  vtcc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// File: design/vtcc_checker.sv
// Port-level checks for the checkpoint controller, bound to the top level.
module vtcc_checker import vtcc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input out_item_t result
);

  // An accepted word makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted word");

  // A result is shown only once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done shown while busy");

  // A result strobe lasts a single cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A restore clears both flags.
  a_restore_flags: assert property (@(posedge clk) disable iff (rst)
    done && (result.action == ACT_RESTORED) |->
      !result.checkpoint_valid && !result.power_off_seen)
    else $error("flags still set after a restore");

  // A save leaves a valid checkpoint.
  a_save_valid: assert property (@(posedge clk) disable iff (rst)
    done && ((result.action == ACT_SAVED) || (result.action == ACT_SAVED_OFF)) |->
      result.checkpoint_valid)
    else $error("checkpoint not valid after a save");

endmodule

bind voltage_triggered_checkpoint_controller vtcc_checker u_vtcc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
